// File: hw/rtl/midi_encoder_move_decoder_assert.svh
// Assertion macros shared by the decoder modules; each expects clk and rst in scope.
`ifndef MIDI_ENCODER_MOVE_DECODER_ASSERT_SVH
`define MIDI_ENCODER_MOVE_DECODER_ASSERT_SVH

// Condition that must hold at every edge outside reset
`define MMD_ASSERT_ALWAYS(lbl, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (c)) else $error(msg);

// Same-cycle implication
`define MMD_ASSERT_IMP(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

// Next-cycle implication
`define MMD_ASSERT_NEXT(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

`endif

// File: hw/rtl/mmd_pkg.sv
// Shared types and constants of the MIDI encoder move decoder.
package mmd_pkg;

  // Controller store
  localparam int NUM_CTL = 128;
  localparam int CTL_W   = 7;
  localparam int CTL_AW  = (NUM_CTL > 1) ? $clog2(NUM_CTL) : 1;
  localparam int VAL_W   = 7;

  // Request queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = Q_AW + 1;

  // Port widths
  localparam int S_TDATA_W = 16;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 32;
  localparam int MOVE_W    = 21;
  localparam int ENC_W     = 7;
  localparam int DET_W     = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 7;

  // Commands
  localparam logic [1:0] OP_DECODE  = 2'd0;
  localparam logic [1:0] OP_SET     = 2'd1;
  localparam logic [1:0] OP_FORGET  = 2'd2;
  localparam logic [1:0] OP_RESTART = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_ENC = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DETECT    = 1'b1;

  // Relative encoding codes
  localparam logic [ENC_W-1:0] ENC_TWOS = 7'd127;
  localparam logic [ENC_W-1:0] ENC_OFS7 = 7'd63;
  localparam logic [ENC_W-1:0] ENC_SMAG = 7'd33;
  localparam logic [ENC_W-1:0] ENC_OFS5 = 7'd15;
  localparam logic [ENC_W-1:0] ENC_SGN6 = 7'd65;
  localparam logic [ENC_W-1:0] ENC_ABS  = 7'd0;

  localparam logic [DET_W-1:0]  DETECT_RESET = 3'd5;
  localparam logic [MOVE_W-1:0] JUMP_POS     = MOVE_W'(1000000);
  localparam logic [MOVE_W-1:0] JUMP_NEG     = MOVE_W'(-1000000);

  // One classified request
  typedef struct packed {
    logic [1:0]       op;
    logic [CTL_W-1:0] ctl;
    logic [VAL_W-1:0] value;
    logic             stored;
  } item_t;

  // Head of the request queue
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

endpackage

// File: hw/rtl/midi_encoder_move_decoder.sv
// Top level of the MIDI encoder move decoder: front end, request queue, execute stage.
//
//  channel   direction  handshake            payload
//  s_*       in         s_tvalid/s_tready    tdata: controller, value; tuser: command
//  m_*       out        m_tvalid/m_tready    tdata: move, mode_switched, active_encoding
//  cfg_*     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One request per cycle sustained while m_tready stays high. A request goes from its queue
// slot to the execute stage (registered store read), then to the result register on m_tvalid.
// The store read-modify-write per request is covered by forwarding the last write.
// Synchronous reset clears all known positions at once and sets the restart state.
// A four-entry queue absorbs output stalls; s_tready drops only when it is full.
module midi_encoder_move_decoder import mmd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,    // controller[6:0], value[13:7], zero pad
  input  logic [S_TUSER_W-1:0] s_tuser,    // command[1:0]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,    // move[20:0], mode_switched[21], active_encoding[28:22]
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  logic    q_ready;
  logic    push;
  item_t   push_item;
  logic    pop;
  q_head_t head;

  assign cfg_ready = 1'b1;

  mmd_front u_front (
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .q_ready   (q_ready),
    .push      (push),
    .push_item (push_item)
  );

  mmd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .q_ready   (q_ready),
    .pop       (pop),
    .head      (head)
  );

  mmd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

// File: hw/rtl/mmd_front.sv
// Front end: takes input requests, unpacks and classifies them for the queue.
module mmd_front import mmd_pkg::*; (
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,  // controller[6:0], value[13:7], zero pad
  input  logic [S_TUSER_W-1:0] s_tuser,  // command[1:0]
  input  logic                 q_ready,
  output logic                 push,
  output item_t                push_item
);

  assign s_tready = q_ready;
  assign push     = s_tvalid && q_ready;

  // Unpack and flag controllers that have a slot in the store
  always_comb begin
    push_item.op     = s_tuser;
    push_item.ctl    = s_tdata[CTL_W-1:0];
    push_item.value  = s_tdata[CTL_W +: VAL_W];
    push_item.stored = ({1'b0, s_tdata[CTL_W-1:0]} < (CTL_W+1)'(NUM_CTL));
  end

endmodule

// File: hw/rtl/mmd_queue.sv
// Short request queue decoupling the front end from the execute stage.
module mmd_queue import mmd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  item_t   push_item,
  output logic    q_ready,
  input  logic    pop,
  output q_head_t head
);

  item_t           entry [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_CW-1:0] count;

  assign q_ready    = (count != Q_CW'(Q_DEPTH));
  assign head.valid = (count != '0);
  assign head.item  = entry[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`include "midi_encoder_move_decoder_assert.svh"
  `MMD_ASSERT_IMP(a_no_pop_empty, pop, count != '0, "queue popped while empty")
  `MMD_ASSERT_IMP(a_no_push_full, push, count != Q_CW'(Q_DEPTH), "queue pushed while full")
  `MMD_ASSERT_ALWAYS(a_count_range, count <= Q_CW'(Q_DEPTH), "queue count out of range")

endmodule

// File: hw/rtl/mmd_back.sv
// Execute stage: controller store, decode state machine data and result register.
module mmd_back import mmd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  q_head_t              head,
  output logic                 pop,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata
);

  localparam logic [1:0] SIGN_ZERO = 2'd0;
  localparam logic [1:0] SIGN_POS  = 2'd1;
  localparam logic [1:0] SIGN_NEG  = 2'd3;

  // Configuration
  logic [ENC_W-1:0] start_enc;
  logic [DET_W-1:0] detect_cnt;

  // Decode state
  logic [ENC_W-1:0] enc_now, enc_next;
  logic [DET_W-1:0] ident_left, ident_left_next;
  logic [CTL_W-1:0] prev_ctl;
  logic             prev_has;
  logic [VAL_W-1:0] prev_val;
  logic [1:0]       prev_sign, prev_sign_next;

  // Controller store: data in a memory, known flags in flops
  logic [VAL_W-1:0] ram [NUM_CTL];
  logic [VAL_W-1:0] ram_q;
  logic [NUM_CTL-1:0] kp_valid;
  logic             fwd_hit;
  logic [VAL_W-1:0] fwd_data;

  // Execute stage
  logic             ex_valid;
  item_t            ex;
  logic             ex_fire, ex_load;
  logic [CTL_AW-1:0] ex_addr, head_addr;
  logic             ram_we;
  logic             pos_known;
  logic [VAL_W-1:0] last;
  logic [8:0]       rel_mv, diff_raw, dr, ad, ar;
  logic             reverse, is_rel;
  logic [MOVE_W-1:0] ex_move;
  logic             ex_switch;

  // Result register
  logic              out_valid;
  logic [MOVE_W-1:0] out_move;
  logic              out_sw;
  logic [ENC_W-1:0]  out_enc;

  assign ex_fire   = ex_valid && (!out_valid || m_tready);
  assign ex_load   = head.valid && (!ex_valid || ex_fire);
  assign pop       = ex_load;
  assign ex_addr   = ex.ctl[CTL_AW-1:0];
  assign head_addr = head.item.ctl[CTL_AW-1:0];

  assign pos_known = ex.stored && kp_valid[ex_addr];
  assign last      = fwd_hit ? fwd_data : ram_q;

  // Relative decodes
  always_comb begin
    is_rel = 1'b1;
    case (enc_now)
      ENC_TWOS: rel_mv = (ex.value < 7'd65) ? {2'b0, ex.value} : {2'b0, ex.value} - 9'd128;
      ENC_OFS7: rel_mv = {2'b0, ex.value} - 9'd64;
      ENC_SMAG: rel_mv = (ex.value < 7'd32) ? {2'b0, ex.value} : 9'd32 - {2'b0, ex.value};
      ENC_OFS5: rel_mv = {2'b0, ex.value} - 9'd16;
      ENC_SGN6: rel_mv = (ex.value < 7'd64) ? {2'b0, ex.value} : 9'd64 - {2'b0, ex.value};
      default: begin
        rel_mv = '0;
        is_rel = 1'b0;
      end
    endcase
  end

  // Absolute difference with reversal smoothing
  always_comb begin
    diff_raw = {2'b0, ex.value} - {2'b0, last};
    dr       = {2'b0, ex.value} - (prev_has ? {2'b0, prev_val} : 9'h1FF);
    ad       = diff_raw[8] ? 9'd0 - diff_raw : diff_raw;
    ar       = dr[8] ? 9'd0 - dr : dr;
    reverse  = (ex.ctl == prev_ctl) &&
               ((!diff_raw[8] && diff_raw != '0 && prev_sign == SIGN_NEG) ||
                (diff_raw[8] && prev_sign == SIGN_POS));
  end

  // Execute one request
  always_comb begin
    ex_move         = '0;
    ex_switch       = 1'b0;
    enc_next        = enc_now;
    ident_left_next = ident_left;
    prev_sign_next  = prev_sign;
    ram_we          = 1'b0;
    case (ex.op)
      OP_DECODE: begin
        if (is_rel) begin
          ex_move = {{(MOVE_W-9){rel_mv[8]}}, rel_mv};
        end else begin
          ram_we = ex.stored;
          if (pos_known) begin
            if (ident_left != '0) begin
              if (prev_has && ex.value != prev_val) begin
                ident_left_next = '0;
              end else begin
                ident_left_next = ident_left - 1'b1;
                if (ident_left == DET_W'(1)) begin
                  enc_next  = ex.value;
                  ex_switch = 1'b1;
                end
              end
            end else if (ex.value == '0) begin
              ex_move = (last == '0) ? '1 : JUMP_NEG;
            end else if (ex.value == '1) begin
              ex_move = (last == '1) ? MOVE_W'(1) : JUMP_POS;
            end else if (reverse && ad > ar) begin
              ex_move = {{(MOVE_W-9){dr[8]}}, dr};
            end else begin
              ex_move = {{(MOVE_W-9){diff_raw[8]}}, diff_raw};
            end
          end
          if (ex_move == '0) begin
            prev_sign_next = SIGN_ZERO;
          end else if (ex_move[MOVE_W-1]) begin
            prev_sign_next = SIGN_NEG;
          end else begin
            prev_sign_next = SIGN_POS;
          end
        end
      end
      OP_SET: ram_we = ex.stored;
      OP_FORGET: ;
      OP_RESTART: begin
        enc_next        = start_enc;
        ident_left_next = (start_enc != ENC_ABS) ? '0 : detect_cnt;
        prev_sign_next  = SIGN_ZERO;
      end
      default: ;
    endcase
  end

  // Store data and registered read with write forwarding
  always_ff @(posedge clk) begin
    if (ex_fire && ram_we) begin
      ram[ex_addr] <= ex.value;
    end
    if (ex_load) begin
      ram_q    <= ram[head_addr];
      fwd_hit  <= ex_fire && ram_we && (ex_addr == head_addr);
      fwd_data <= ex.value;
    end
  end

  // Execute stage register
  always_ff @(posedge clk) begin
    if (ex_load) begin
      ex <= head.item;
    end
  end

  // Control and decode state
  always_ff @(posedge clk) begin
    if (rst) begin
      start_enc  <= ENC_ABS;
      detect_cnt <= DETECT_RESET;
      enc_now    <= ENC_ABS;
      ident_left <= DETECT_RESET;
      prev_ctl   <= '0;
      prev_has   <= 1'b0;
      prev_val   <= '0;
      prev_sign  <= SIGN_ZERO;
      kp_valid   <= '0;
      ex_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_START_ENC: start_enc  <= cfg_data;
          CFG_DETECT:    detect_cnt <= cfg_data[DET_W-1:0];
          default: ;
        endcase
      end
      if (ex_load) begin
        ex_valid <= 1'b1;
      end else if (ex_fire) begin
        ex_valid <= 1'b0;
      end
      if (ex_fire) begin
        out_valid  <= 1'b1;
        enc_now    <= enc_next;
        ident_left <= ident_left_next;
        prev_sign  <= prev_sign_next;
        if (ex.op == OP_RESTART) begin
          kp_valid <= '0;
          prev_ctl <= '0;
          prev_has <= 1'b0;
        end else if (ex.op == OP_DECODE && !is_rel) begin
          prev_ctl <= ex.ctl;
          prev_has <= 1'b1;
          prev_val <= ex.value;
        end
        if (ram_we) begin
          kp_valid[ex_addr] <= 1'b1;
        end else if (ex.op == OP_FORGET && ex.stored) begin
          kp_valid[ex_addr] <= 1'b0;
        end
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (ex_fire) begin
      out_move <= ex_move;
      out_sw   <= ex_switch;
      out_enc  <= enc_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {(M_TDATA_W-MOVE_W-1-ENC_W)'(0), out_enc, out_sw, out_move};

`include "midi_encoder_move_decoder_assert.svh"
  `MMD_ASSERT_NEXT(a_restart_clears, ex_fire && ex.op == OP_RESTART, kp_valid == '0, "restart left known positions")
  `MMD_ASSERT_NEXT(a_switch_ends_count, ex_fire && ex_switch, ident_left == '0 && enc_now == $past(ex.value), "mode switch did not load encoding")
  `MMD_ASSERT_NEXT(a_set_marks_known, ex_fire && ex.op == OP_SET && ex.stored, kp_valid[$past(ex_addr)], "set position not marked known")

endmodule

// File: tb/mmd_move_checker.sv
// Checker for the MIDI encoder move decoder: watches all channels, predicts each move and compares.
module mmd_move_checker import mmd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,    // controller[6:0], value[13:7], zero pad
  input  logic [S_TUSER_W-1:0] s_tuser,    // command[1:0]
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [M_TDATA_W-1:0] m_tdata,    // move[20:0], mode_switched[21], active_encoding[28:22]
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  output int                   mismatch_count,
  output int                   moves_pending
);

  localparam int JUMP = 1000000;

  typedef struct packed {
    logic [MOVE_W-1:0] move;
    logic              switched;
    logic [ENC_W-1:0]  enc;
  } move_result_t;

  move_result_t expected_moves[$];

  // Configuration copy
  logic [ENC_W-1:0] start_enc;
  logic [DET_W-1:0] detect_cnt;

  // Decoder state copy
  logic signed [7:0] known_pos [NUM_CTL];
  logic [ENC_W-1:0]  enc_now;
  logic [DET_W-1:0]  ident_left;
  logic [CTL_W-1:0]  prev_ctl;
  logic signed [7:0] prev_val;
  int                prev_sign;

  function automatic int sign_of(input int d);
    return (d > 0) ? 1 : ((d < 0) ? -1 : 0);
  endfunction

  // Restart: forget every position, load the start encoding
  task automatic restart_store();
    for (int i = 0; i < NUM_CTL; i++) known_pos[i] = -1;
    enc_now    = start_enc;
    ident_left = (start_enc != ENC_ABS) ? '0 : detect_cnt;
    prev_ctl   = '0;
    prev_val   = -1;
    prev_sign  = 0;
  endtask

  // Absolute mode: difference from the known position, countdown of identical readings
  task automatic absolute_step(input logic [CTL_W-1:0] ctl, input int v,
                               output int diff, output logic sw);
    int last;
    int dr;
    int ad;
    int ar;
    last = -1;
    diff = 0;
    sw   = 1'b0;
    if (ctl < NUM_CTL) begin
      last          = known_pos[ctl];
      known_pos[ctl] = 8'(v);
    end
    if (last != -1) begin
      if (ident_left != 0) begin
        if (v != prev_val && prev_val != -1) begin
          ident_left = '0;
        end else begin
          ident_left = ident_left - 1'b1;
          if (ident_left == 0) begin
            enc_now = v[ENC_W-1:0];
            sw      = 1'b1;
          end
        end
      end else if (v == 0) begin
        diff = (last == 0) ? -1 : -JUMP;
      end else if (v == 127) begin
        diff = (last == 127) ? 1 : JUMP;
      end else begin
        diff = v - last;
        // reversal smoothing on the same controller
        if (ctl == prev_ctl && sign_of(diff) * prev_sign < 0) begin
          dr = v - prev_val;
          ad = (diff < 0) ? -diff : diff;
          ar = (dr < 0) ? -dr : dr;
          if (ad > ar) diff = dr;
        end
      end
    end
    prev_ctl  = ctl;
    prev_val  = 8'(v);
    prev_sign = sign_of(diff);
  endtask

  // Work out the result of one request and queue it
  task automatic decode_request(input logic [1:0] cmd, input logic [CTL_W-1:0] ctl,
                                input logic [VAL_W-1:0] val);
    int           v;
    int           move;
    logic         sw;
    move_result_t res;
    v    = val;
    move = 0;
    sw   = 1'b0;
    case (cmd)
      OP_DECODE: begin
        case (enc_now)
          ENC_TWOS: move = (v < 65) ? v : v - 128;
          ENC_OFS7: move = v - 64;
          ENC_SMAG: move = (v < 32) ? v : 32 - v;
          ENC_OFS5: move = v - 16;
          ENC_SGN6: move = (v < 64) ? v : 64 - v;
          default:  absolute_step(ctl, v, move, sw);
        endcase
      end
      OP_SET: begin
        if (ctl < NUM_CTL) known_pos[ctl] = 8'(v);
      end
      OP_FORGET: begin
        if (ctl < NUM_CTL) known_pos[ctl] = -1;
      end
      default: restart_store();
    endcase
    res.move     = MOVE_W'(move);
    res.switched = sw;
    res.enc      = enc_now;
    expected_moves.push_back(res);
  endtask

  // Sample every channel at the rising edge
  always @(posedge clk) begin : monitor
    move_result_t want;
    move_result_t got;
    if (rst) begin
      mismatch_count = 0;
      expected_moves.delete();
      start_enc  = ENC_ABS;
      detect_cnt = DETECT_RESET;
      restart_store();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_START_ENC: start_enc = cfg_data[ENC_W-1:0];
          CFG_DETECT:    detect_cnt = cfg_data[DET_W-1:0];
        endcase
      end
      if (m_tvalid && m_tready) begin
        got.move     = m_tdata[MOVE_W-1:0];
        got.switched = m_tdata[MOVE_W];
        got.enc      = m_tdata[MOVE_W+1 +: ENC_W];
        if (expected_moves.size() == 0) begin
          $display("%0t: result with no request pending, tdata %h", $time, m_tdata);
          mismatch_count++;
        end else begin
          want = expected_moves.pop_front();
          if (got.move !== want.move) begin
            $display("%0t: move expected %0d actual %0d", $time,
                     $signed(want.move), $signed(got.move));
            mismatch_count++;
          end
          if (got.switched !== want.switched) begin
            $display("%0t: mode_switched expected %0b actual %0b", $time,
                     want.switched, got.switched);
            mismatch_count++;
          end
          if (got.enc !== want.enc) begin
            $display("%0t: active_encoding expected %0d actual %0d", $time,
                     want.enc, got.enc);
            mismatch_count++;
          end
        end
      end
      if (s_tvalid && s_tready)
        decode_request(s_tuser, s_tdata[CTL_W-1:0], s_tdata[CTL_W +: VAL_W]);
    end
    moves_pending = expected_moves.size();
  end

endmodule

// File: tb/midi_encoder_move_decoder_tb.sv
// Testbench top for the MIDI encoder move decoder: clock, reset, requests, config and verdict.
module midi_encoder_move_decoder_tb;
  import mmd_pkg::*;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;    // controller[6:0], value[13:7], zero pad
  logic [S_TUSER_W-1:0] s_tuser;    // command[1:0]
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;    // move[20:0], mode_switched[21], active_encoding[28:22]
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  int   mismatch_count;
  int   moves_pending;
  logic no_idle;
  int   last_ctl;
  int   last_val;

  midi_encoder_move_decoder i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mmd_move_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .moves_pending  (moves_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #5000000;
    $display("FAILURE");
    $finish;
  end

  // Result side stalls at random
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_tready <= no_idle || ($urandom_range(99) >= 15);
    end
  end

  // One request; called at a falling edge, returns at the falling edge after accept
  task automatic send_request(input logic [1:0] cmd, input logic [CTL_W-1:0] ctl,
                              input logic [VAL_W-1:0] val);
    while (!no_idle && $urandom_range(99) < 15) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= S_TDATA_W'({val, ctl});
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Wait until every queued move has come out
  task automatic drain_moves();
    s_tvalid <= 1'b0;
    while (moves_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [VAL_W-1:0] relative_code();
    case ($urandom_range(4))
      0:       return ENC_TWOS;
      1:       return ENC_OFS7;
      2:       return ENC_SMAG;
      3:       return ENC_OFS5;
      default: return ENC_SGN6;
    endcase
  endfunction

  // Mostly knob turns on a few controllers, with runs of identical readings
  task automatic random_request();
    int r;
    int ctl;
    int val;
    r = $urandom_range(99);
    if (r < 4) begin
      send_request(OP_RESTART, 7'($urandom), 7'($urandom));
    end else if (r < 12) begin
      ctl = (r < 9) ? last_ctl : $urandom_range(127);
      send_request(OP_SET, 7'(ctl), 7'($urandom));
    end else if (r < 17) begin
      ctl = (r < 15) ? last_ctl : $urandom_range(127);
      send_request(OP_FORGET, 7'(ctl), 7'($urandom));
    end else begin
      r = $urandom_range(99);
      if (r < 60)      ctl = last_ctl;
      else if (r < 85) ctl = $urandom_range(3);
      else             ctl = $urandom_range(127);
      r = $urandom_range(99);
      if (r < 30) begin
        val = last_val;
      end else if (r < 55) begin
        val = last_val + $urandom_range(8) - 4;
        if (val < 0) val = 0;
        if (val > 127) val = 127;
      end else if (r < 65) begin
        val = (r < 60) ? 0 : 127;
      end else if (r < 72) begin
        val = relative_code();
      end else begin
        val = $urandom_range(127);
      end
      last_ctl = ctl;
      last_val = val;
      send_request(OP_DECODE, 7'(ctl), 7'(val));
    end
  endtask

  // New register setting, restart, a few edge values, then random traffic
  task automatic run_phase(input logic [ENC_W-1:0] start_code, input logic [DET_W-1:0] detect,
                           input int count);
    drain_moves();
    write_reg(CFG_START_ENC, start_code);
    write_reg(CFG_DETECT, {4'($urandom_range(15)), detect});
    cfg_valid <= 1'b0;
    send_request(OP_RESTART, 7'($urandom), 7'($urandom));
    send_request(OP_DECODE, 7'($urandom_range(3)), 7'd0);
    send_request(OP_DECODE, 7'($urandom_range(3)), 7'd32);
    send_request(OP_DECODE, 7'($urandom_range(3)), 7'd64);
    send_request(OP_DECODE, 7'($urandom_range(3)), 7'd127);
    repeat (count) random_request();
  endtask

  initial begin
    rst       = 1'b1;
    no_idle   = 1'b0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = OP_DECODE;
    cfg_valid = 1'b0;
    cfg_index = CFG_START_ENC;
    cfg_data  = '0;
    last_ctl  = 0;
    last_val  = 64;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // Directed: countdown to a non-relative code, jumps, smoothing, forget, top controller
    send_request(OP_DECODE, 7'd5, 7'd40);
    repeat (5) send_request(OP_DECODE, 7'd5, 7'd40);
    send_request(OP_DECODE, 7'd5, 7'd60);
    send_request(OP_DECODE, 7'd5, 7'd50);
    send_request(OP_SET, 7'd5, 7'd20);
    send_request(OP_DECODE, 7'd5, 7'd60);
    send_request(OP_DECODE, 7'd5, 7'd0);
    send_request(OP_DECODE, 7'd5, 7'd0);
    send_request(OP_DECODE, 7'd5, 7'd127);
    send_request(OP_DECODE, 7'd5, 7'd127);
    send_request(OP_FORGET, 7'd5, 7'd0);
    send_request(OP_DECODE, 7'd5, 7'd30);
    send_request(OP_DECODE, 7'd127, 7'd127);
    send_request(OP_DECODE, 7'd127, 7'd126);
    send_request(OP_SET, 7'd127, 7'd0);
    send_request(OP_DECODE, 7'd127, 7'd127);
    send_request(OP_RESTART, 7'd0, 7'd0);
    send_request(OP_DECODE, 7'd0, 7'd0);

    // Register settings, extremes included
    run_phase(ENC_ABS, DETECT_RESET, 190);
    run_phase(ENC_TWOS, 3'd0, 185);
    no_idle = 1'b1;
    run_phase(ENC_OFS7, 3'd7, 185);
    no_idle = 1'b0;
    run_phase(ENC_SMAG, 3'd1, 185);
    run_phase(ENC_OFS5, 3'd3, 185);
    run_phase(ENC_SGN6, 3'd2, 185);
    run_phase(ENC_ABS, 3'd0, 185);
    run_phase(ENC_ABS, 3'd7, 185);
    run_phase(ENC_ABS, 3'd1, 185);
    run_phase(7'd100, 3'd4, 185);
    drain_moves();

    if (mismatch_count == 0 && moves_pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: midi_encoder_move_decoder.f
+incdir+hw/rtl
hw/rtl/mmd_pkg.sv
hw/rtl/mmd_front.sv
hw/rtl/mmd_queue.sv
hw/rtl/mmd_back.sv
hw/rtl/midi_encoder_move_decoder.sv
tb/mmd_move_checker.sv
tb/midi_encoder_move_decoder_tb.sv
